// ----- sv/ctq_pkg.sv -----
// ----------------------------------------------------------------------------
// ctq_pkg
// Shared types and constants for the capacitive touch qualifier.
// ----------------------------------------------------------------------------
package ctq_pkg;

  localparam int unsigned FRAC_BITS  = 4;
  localparam int unsigned LEVEL_W    = 16 + FRAC_BITS;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_MAX_LEVEL   = 3'd0,
    REG_PRESS_THR   = 3'd1,
    REG_RELEASE_THR = 3'd2,
    REG_REQ_COUNT   = 3'd3,
    REG_LOCKOUT_MS  = 3'd4
  } reg_idx_t;

  localparam logic [15:0] MAX_LEVEL_RST   = 16'd65535;
  localparam logic [15:0] PRESS_THR_RST   = 16'd1000;
  localparam logic [15:0] RELEASE_THR_RST = 16'd500;
  localparam logic [7:0]  REQ_COUNT_RST   = 8'd3;
  localparam logic [15:0] LOCKOUT_MS_RST  = 16'd200;

  typedef struct packed {
    logic [15:0] cap_sample;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [15:0] level;
    logic        is_pressed;
    logic        toggled;
    logic        switch_on;
  } out_item_t;

  typedef struct packed {
    logic [15:0] max_level;
    logic [15:0] press_threshold;
    logic [15:0] release_threshold;
    logic [7:0]  required_count;
    logic [15:0] lockout_ms;
  } cfg_t;

endpackage

// ----- sv/ctq_cfg.sv -----
// ----------------------------------------------------------------------------
// ctq_cfg
// APB-style configuration registers with read back.
// ----------------------------------------------------------------------------
module ctq_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ctq_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ctq_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ctq_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  output ctq_pkg::cfg_t                      cfg
);

  ctq_pkg::cfg_t    cfg_r;
  ctq_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx    = ctq_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_level         <= ctq_pkg::MAX_LEVEL_RST;
      cfg_r.press_threshold   <= ctq_pkg::PRESS_THR_RST;
      cfg_r.release_threshold <= ctq_pkg::RELEASE_THR_RST;
      cfg_r.required_count    <= ctq_pkg::REQ_COUNT_RST;
      cfg_r.lockout_ms        <= ctq_pkg::LOCKOUT_MS_RST;
    end else if (wr_en) begin
      case (idx)
        ctq_pkg::REG_MAX_LEVEL:   cfg_r.max_level         <= pwdata[15:0];
        ctq_pkg::REG_PRESS_THR:   cfg_r.press_threshold   <= pwdata[15:0];
        ctq_pkg::REG_RELEASE_THR: cfg_r.release_threshold <= pwdata[15:0];
        ctq_pkg::REG_REQ_COUNT:   cfg_r.required_count    <= pwdata[7:0];
        ctq_pkg::REG_LOCKOUT_MS:  cfg_r.lockout_ms        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ctq_pkg::REG_MAX_LEVEL:   prdata = {16'd0, cfg_r.max_level};
      ctq_pkg::REG_PRESS_THR:   prdata = {16'd0, cfg_r.press_threshold};
      ctq_pkg::REG_RELEASE_THR: prdata = {16'd0, cfg_r.release_threshold};
      ctq_pkg::REG_REQ_COUNT:   prdata = {24'd0, cfg_r.required_count};
      ctq_pkg::REG_LOCKOUT_MS:  prdata = {16'd0, cfg_r.lockout_ms};
      default:                  prdata = '0;
    endcase
  end

endmodule

// ----- sv/ctq_core.sv -----
// ----------------------------------------------------------------------------
// ctq_core
// Level filter and press/release qualifier; state advances once per item.
// ----------------------------------------------------------------------------
module ctq_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  ctq_pkg::in_item_t  item,
  input  ctq_pkg::cfg_t      cfg,
  output ctq_pkg::out_item_t res
);

  localparam int unsigned LW = ctq_pkg::LEVEL_W;
  localparam int unsigned FB = ctq_pkg::FRAC_BITS;

  logic [LW-1:0] filt_r, filt_nxt;
  logic          pressed_r, pressed_nxt;
  logic [31:0]   lock_r, lock_nxt;
  logic [7:0]    run_r, run_nxt;
  logic          sw_r, sw_nxt;

  logic [LW:0]   sum;
  logic [LW-1:0] avg, cap, lvl;
  logic [7:0]    cnt_inc;
  logic          reached, press_ok, rel_ok, toggled;

  always_comb begin
    sum     = {1'b0, filt_r} + {1'b0, item.cap_sample, {FB{1'b0}}};
    avg     = sum[LW:1];
    cap     = {cfg.max_level, {FB{1'b0}}};
    lvl     = (avg > cap) ? cap : avg;
    cnt_inc = (run_r == 8'hFF) ? run_r : run_r + 8'd1;
    reached = cnt_inc >= cfg.required_count;
    press_ok = !pressed_r && (lvl >= {cfg.press_threshold, {FB{1'b0}}})
               && (item.now_ms >= lock_r);
    rel_ok   = pressed_r && (lvl <= {cfg.release_threshold, {FB{1'b0}}});

    filt_nxt    = lvl;
    pressed_nxt = pressed_r;
    lock_nxt    = lock_r;
    run_nxt     = 8'd0;
    sw_nxt      = sw_r;
    toggled     = 1'b0;
    if (press_ok) begin
      run_nxt = cnt_inc;
      if (reached) begin
        sw_nxt      = !sw_r;
        toggled     = 1'b1;
        pressed_nxt = 1'b1;
        run_nxt     = 8'd0;
      end
    end else if (rel_ok) begin
      run_nxt = cnt_inc;
      if (reached) begin
        pressed_nxt = 1'b0;
        run_nxt     = 8'd0;
        lock_nxt    = item.now_ms + {16'd0, cfg.lockout_ms};
      end
    end

    res.level      = lvl[LW-1:FB];
    res.is_pressed = pressed_nxt;
    res.toggled    = toggled;
    res.switch_on  = sw_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r    <= '0;
      pressed_r <= 1'b0;
      lock_r    <= '0;
      run_r     <= '0;
      sw_r      <= 1'b0;
    end else if (step) begin
      filt_r    <= filt_nxt;
      pressed_r <= pressed_nxt;
      lock_r    <= lock_nxt;
      run_r     <= run_nxt;
      sw_r      <= sw_nxt;
    end
  end

endmodule

// ----- sv/capacitive_touch_qualifier_unit.sv -----
// ----------------------------------------------------------------------------
// capacitive_touch_qualifier_unit
// Filters capacitive samples and qualifies touch presses into a toggle.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  ctq_pkg::in_item_t
//   out_     output     out_valid/out_stall ctq_pkg::out_item_t
//   cfg      input      psel/penable       paddr/pwdata/prdata (APB-style)
//
// One item per cycle sustained while out_stall is low; out_valid rises
// once the beat in the input register has moved into the result register.
// The filter/qualifier state is updated as an item moves into the result
// register, so each item sees the state left by the one before.
// out_stall holds the result register; in_stall rises only when both
// registers are full and out_stall is high. rst_n is synchronous and
// restores register defaults.
// ----------------------------------------------------------------------------
module capacitive_touch_qualifier_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ctq_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ctq_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ctq_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ctq_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ctq_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  ctq_pkg::cfg_t      cfg;
  ctq_pkg::in_item_t  in_r;
  logic               in_vld_r;
  ctq_pkg::out_item_t out_r, res;
  logic               out_vld_r;
  logic               advance;

  ctq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ctq_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_toggle_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.toggled |-> out_data.is_pressed)
    else $error("toggle reported without pressed state");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r && out_stall))
    else $error("input stalled with room in pipeline");

  a_level_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.level <= cfg.max_level))
    else $error("level above clamp");
`endif

endmodule

// ----- tb/sv/capacitive_touch_qualifier_unit_test.sv -----
// ----------------------------------------------------------------------------
// capacitive_touch_qualifier_unit_test
// Self-checking bench for the touch qualifier. A queue-fed driver sends
// sample/time beats and an in-bench filter and press/release tracker predicts
// each result. A monitor checks every result beat against the oldest
// prediction. Both sides pause at random. Registers are rewritten over APB
// between phases, once the pipe has drained.
// ----------------------------------------------------------------------------
module capacitive_touch_qualifier_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  ctq_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ctq_pkg::out_item_t out_data;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ctq_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [ctq_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [ctq_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  capacitive_touch_qualifier_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the block's registers and tracker state
  ctq_pkg::cfg_t cfg_model = '{max_level: ctq_pkg::MAX_LEVEL_RST,
                               press_threshold: ctq_pkg::PRESS_THR_RST,
                               release_threshold: ctq_pkg::RELEASE_THR_RST,
                               required_count: ctq_pkg::REQ_COUNT_RST,
                               lockout_ms: ctq_pkg::LOCKOUT_MS_RST};
  logic [ctq_pkg::LEVEL_W-1:0] filt_q = '0;
  logic pressed_q = 1'b0;
  logic [31:0] lock_until_q = '0;
  logic [7:0] run_q = '0;
  logic switch_q = 1'b0;

  ctq_pkg::in_item_t pending_samples[$];
  ctq_pkg::out_item_t expected_reports[$];
  ctq_pkg::out_item_t want_report;
  logic [31:0] clock_ms = '0;
  int mismatches = 0;
  int cycle_cnt = 0;

  int in_gap = 0;
  int in_calm = 0;
  int out_hold = 0;
  int out_calm = 0;

  function automatic logic run_reached();
    if (run_q != 8'hFF) run_q = run_q + 8'd1;
    return run_q >= cfg_model.required_count;
  endfunction

  // Advance the filter and the press/release tracker by one sample
  function automatic ctq_pkg::out_item_t qualify_sample(ctq_pkg::in_item_t it);
    logic [ctq_pkg::LEVEL_W:0] sum;
    logic [ctq_pkg::LEVEL_W-1:0] cap;
    ctq_pkg::out_item_t r;
    sum = {1'b0, filt_q} + {1'b0, it.cap_sample, 4'b0000};
    filt_q = sum[ctq_pkg::LEVEL_W:1];
    cap = {cfg_model.max_level, 4'b0000};
    if (filt_q > cap) filt_q = cap;
    r.toggled = 1'b0;
    if (!pressed_q && filt_q >= {cfg_model.press_threshold, 4'b0000}
        && it.now_ms >= lock_until_q) begin
      if (run_reached()) begin
        switch_q = ~switch_q;
        r.toggled = 1'b1;
        pressed_q = 1'b1;
        run_q = '0;
      end
    end else if (pressed_q && filt_q <= {cfg_model.release_threshold, 4'b0000}) begin
      if (run_reached()) begin
        pressed_q = 1'b0;
        run_q = '0;
        lock_until_q = it.now_ms + {16'h0000, cfg_model.lockout_ms};
      end
    end else begin
      run_q = '0;
    end
    r.level = filt_q[ctq_pkg::LEVEL_W-1:ctq_pkg::FRAC_BITS];
    r.is_pressed = pressed_q;
    r.switch_on = switch_q;
    return r;
  endfunction

  // Mostly short pauses, a few long ones, none while a calm stretch runs
  function automatic int pause_len(int calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0 || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int next_calm(int calm);
    if (calm > 0) return calm - 1;
    return ($urandom_range(0, 49) == 0) ? $urandom_range(30, 100) : 0;
  endfunction

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
      in_calm <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_reports.push_back(qualify_sample(in_data));
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_samples.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_samples.pop_front();
        in_gap <= pause_len(in_calm);
        in_calm <= next_calm(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and result-side stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold <= 0;
      out_calm <= 0;
    end else begin
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold <= out_hold - 1;
      end else begin
        out_stall <= 1'b0;
        out_hold <= pause_len(out_calm);
        out_calm <= next_calm(out_calm);
      end
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("result beat with no expectation pending: %p", out_data);
          mismatches++;
        end else begin
          want_report = expected_reports.pop_front();
          if (out_data.level !== want_report.level) begin
            $error("level: expected %0d, got %0d", want_report.level, out_data.level);
            mismatches++;
          end
          if (out_data.is_pressed !== want_report.is_pressed) begin
            $error("is_pressed: expected %0b, got %0b",
                   want_report.is_pressed, out_data.is_pressed);
            mismatches++;
          end
          if (out_data.toggled !== want_report.toggled) begin
            $error("toggled: expected %0b, got %0b", want_report.toggled, out_data.toggled);
            mismatches++;
          end
          if (out_data.switch_on !== want_report.switch_on) begin
            $error("switch_on: expected %0b, got %0b",
                   want_report.switch_on, out_data.switch_on);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_item(input logic [15:0] sample, input logic [31:0] now);
    ctq_pkg::in_item_t it;
    it.cap_sample = sample;
    it.now_ms = now;
    pending_samples.push_back(it);
  endtask

  task automatic write_reg(input ctq_pkg::reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ctq_pkg::REG_MAX_LEVEL:   cfg_model.max_level = val[15:0];
      ctq_pkg::REG_PRESS_THR:   cfg_model.press_threshold = val[15:0];
      ctq_pkg::REG_RELEASE_THR: cfg_model.release_threshold = val[15:0];
      ctq_pkg::REG_REQ_COUNT:   cfg_model.required_count = val[7:0];
      ctq_pkg::REG_LOCKOUT_MS:  cfg_model.lockout_ms = val[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] max_lvl, input logic [15:0] press,
                                input logic [15:0] rel, input logic [7:0] req,
                                input logic [15:0] lock);
    write_reg(ctq_pkg::REG_MAX_LEVEL, {16'h0, max_lvl});
    write_reg(ctq_pkg::REG_PRESS_THR, {16'h0, press});
    write_reg(ctq_pkg::REG_RELEASE_THR, {16'h0, rel});
    write_reg(ctq_pkg::REG_REQ_COUNT, {24'h0, req});
    write_reg(ctq_pkg::REG_LOCKOUT_MS, {16'h0, lock});
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Press/release episodes with random content, plus noise and clock jumps
  task automatic queue_phase(input int budget);
    int made;
    int kind;
    int req;
    int hold;
    int k;
    made = 0;
    while (made < budget) begin
      kind = $urandom_range(0, 9);
      req = (cfg_model.required_count == 0) ? 1 : int'(cfg_model.required_count);
      if (kind == 0) begin
        hold = $urandom_range(1, 8);
        for (k = 0; k < hold; k++) push_item(16'($urandom), $urandom);
        made += hold;
      end else if (kind == 1) begin
        // sometimes park the clock just short of wrapping
        clock_ms = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                        : $urandom;
      end else begin
        hold = $urandom_range(1, req + 12);
        for (k = 0; k < hold; k++) begin
          push_item(16'($urandom_range(cfg_model.press_threshold, 16'hFFFF)), clock_ms);
          clock_ms += $urandom_range(0, 3);
        end
        made += hold;
        hold = $urandom_range(1, req + 12);
        for (k = 0; k < hold; k++) begin
          push_item(16'($urandom_range(0, cfg_model.release_threshold)), clock_ms);
          clock_ms += $urandom_range(0, 3);
        end
        made += hold;
        // land either inside or past the lockout window
        clock_ms += $urandom_range(0, 2 * cfg_model.lockout_ms + 4);
      end
    end
  endtask

  initial begin
    int p;
    int m;
    int pr;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: press, hold at max time, release, press inside and at
    // the end of the lockout
    push_item(16'h0000, 32'd0);
    push_item(16'hFFFF, 32'd0);
    push_item(16'hFFFF, 32'd1);
    push_item(16'hFFFF, 32'd2);
    push_item(16'hFFFF, 32'hFFFF_FFFF);
    repeat (10) push_item(16'h0000, 32'd100);
    repeat (3) push_item(16'hFFFF, 32'd150);
    push_item(16'hFFFF, 32'd300);
    push_item(16'hFFFF, 32'd301);
    push_item(16'hFFFF, 32'd302);
    queue_phase(150);

    for (p = 1; p <= 8; p++) begin
      wait_drained();
      case (p)
        1: apply_settings(16'd0, 16'd0, 16'd0, 8'd1, 16'd0);
        2: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF);
        3: apply_settings(16'hFFFF, 16'd2000, 16'd1000, 8'd255, 16'hFFFF);
        4: apply_settings(16'd40000, 16'd30000, 16'd10000, 8'd0, 16'd10);
        8: apply_settings(16'd3000, 16'd50000, 16'd100, 8'd2, 16'd5);
        default: begin
          m = $urandom_range(1000, 65535);
          pr = $urandom_range(0, m);
          apply_settings(16'(m), 16'(pr), 16'($urandom_range(0, pr)),
                         8'($urandom_range(1, 8)), 16'($urandom_range(0, 1000)));
        end
      endcase
      queue_phase((p == 2 || p == 3) ? 250 : 150);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
